>>> rtl/led_one_wire_pulse_encoder_macros.svh
// Assertion macros shared by the pulse encoder modules.
`ifndef LED_ONE_WIRE_PULSE_ENCODER_MACROS_SVH
`define LED_ONE_WIRE_PULSE_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LOWPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LOWPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/lowpe_pkg.sv
// Types and constants shared by the pulse encoder modules.
package lowpe_pkg;

	localparam int unsigned SEG_W = 5;

	localparam logic [SEG_W-1:0] SEG_LATCH    = 5'd0;
	localparam logic [SEG_W-1:0] SEG_LAST_BIT = 5'd16;
	localparam logic [SEG_W-1:0] SEG_FIRST_BIT = 5'd1;
	localparam logic [SEG_W-1:0] SEG_IDLE     = 5'd17;

	localparam int unsigned REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_ONE_HIGH    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ONE_LOW     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_HIGH   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_LOW    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_RESET = 3'd4;

	typedef struct packed {
		logic [7:0]       colour_byte;
		logic [SEG_W-1:0] first_seg;
		logic [SEG_W-1:0] end_seg;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

	typedef struct packed {
		logic [7:0]  one_high_cycles;
		logic [7:0]  one_low_cycles;
		logic [7:0]  zero_high_cycles;
		logic [7:0]  zero_low_cycles;
		logic [15:0] frame_reset_cycles;
	} cfg_t;

	// A hold time of zero would mean "hold forever", so it is raised to one cycle.
	function automatic logic [15:0] at_least_one(input logic [15:0] v);
		at_least_one = (v == 16'd0) ? 16'd1 : v;
	endfunction

endpackage

>>> rtl/lowpe_front.sv
// Input side: accepts bytes, works out their segment range and queues them.
`include "led_one_wire_pulse_encoder_macros.svh"

module lowpe_front #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        colour_byte,
	input  logic              first_of_frame,
	input  logic              last_of_frame,
	output lowpe_pkg::head_t  head,
	input  logic              head_pop
);
	import lowpe_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t              item_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               wr_en;
	logic               rd_en;
	item_t              new_item;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign wr_en = push && !full;
	assign rd_en = head_pop && (count_q != '0);

	always_comb begin
		new_item.colour_byte = colour_byte;
		new_item.first_seg   = first_of_frame ? SEG_LATCH : SEG_FIRST_BIT;
		new_item.end_seg     = last_of_frame ? SEG_IDLE : SEG_LAST_BIT;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			item_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = item_q[rd_ptr_q];

	`LOWPE_ASSERT_NOW(a_pop_needs_entry, clk, arst_n, head_pop, count_q != '0, "Queue popped while empty.")
	`LOWPE_ASSERT_NEXT(a_count_grows, clk, arst_n, wr_en && !rd_en, count_q == $past(count_q) + 1'b1, "Queue count did not follow a write.")

endmodule

>>> rtl/lowpe_back.sv
// Segment sequencer: plays the head byte out as line segments into the output register.
`include "led_one_wire_pulse_encoder_macros.svh"

module lowpe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  lowpe_pkg::cfg_t  cfg,
	input  lowpe_pkg::head_t head,
	output logic             head_pop,
	output logic             empty,
	input  logic             pop,
	output logic             line_level,
	output logic [15:0]      hold_cycles,
	output logic             run_end
);
	import lowpe_pkg::*;

	logic             started_q;
	logic [SEG_W-1:0] seg_q;
	logic             out_valid_q;
	logic             level_q;
	logic [15:0]      hold_q;
	logic             run_end_q;

	logic             can_load;
	logic             emit;
	logic [SEG_W-1:0] cur;
	logic [SEG_W-1:0] bit_step;
	logic             seg_end;
	logic             data_bit;
	logic             seg_level;
	logic [15:0]      seg_hold;

	assign can_load = !out_valid_q || pop;
	assign emit     = head.valid && can_load;
	assign cur      = started_q ? seg_q : head.item.first_seg;
	assign seg_end  = (cur == head.item.end_seg);
	assign head_pop = emit && seg_end;
	assign bit_step = cur - SEG_FIRST_BIT;
	assign data_bit = head.item.colour_byte[3'd7 - bit_step[3:1]];

	always_comb begin
		if (cur == SEG_LATCH) begin
			seg_level = 1'b0;
			seg_hold  = at_least_one(cfg.frame_reset_cycles);
		end else if (cur == SEG_IDLE) begin
			seg_level = 1'b1;
			seg_hold  = 16'd0;
		end else if (!bit_step[0]) begin
			seg_level = 1'b1;
			seg_hold  = at_least_one({8'd0, data_bit ? cfg.one_high_cycles
			                                         : cfg.zero_high_cycles});
		end else begin
			seg_level = 1'b0;
			seg_hold  = at_least_one({8'd0, data_bit ? cfg.one_low_cycles
			                                         : cfg.zero_low_cycles});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			seg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				started_q <= !seg_end;
				seg_q     <= cur + 1'b1;
			end
			if (can_load) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			level_q   <= seg_level;
			hold_q    <= seg_hold;
			run_end_q <= seg_end;
		end
	end

	assign empty       = !out_valid_q;
	assign line_level  = level_q;
	assign hold_cycles = hold_q;
	assign run_end     = run_end_q;

	`LOWPE_ASSERT_NOW(a_seg_in_range, clk, arst_n, started_q, seg_q <= SEG_IDLE, "Segment index ran past the idle segment.")
	`LOWPE_ASSERT_NOW(a_latch_only_at_start, clk, arst_n, emit && (cur == SEG_LATCH), !started_q, "Latch segment emitted inside a byte.")

endmodule

>>> rtl/led_one_wire_pulse_encoder.sv
// Top level of the one-wire LED pulse encoder: configuration registers and the two halves.
// A byte accepted into the input queue is played out segment by segment into the output register.
// A byte is 16 to 18 segments, one per cycle while the output register is empty or popped.
// Up to QUEUE_DEPTH bytes wait in the input queue while the sequencer works.
// Reset clears the queue and output register and restores the timing registers
// to 40, 35, 15, 40 and 15000.
module led_one_wire_pulse_encoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [7:0]                     colour_byte,
	input  logic                           first_of_frame,
	input  logic                           last_of_frame,
	output logic                           empty,
	input  logic                           pop,
	output logic                           line_level,
	output logic [15:0]                    hold_cycles,
	output logic                           run_end,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lowpe_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);
	import lowpe_pkg::*;

	cfg_t  cfg_q;
	head_t head;
	logic  head_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_high_cycles    <= 8'd40;
			cfg_q.one_low_cycles     <= 8'd35;
			cfg_q.zero_high_cycles   <= 8'd15;
			cfg_q.zero_low_cycles    <= 8'd40;
			cfg_q.frame_reset_cycles <= 16'd15000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ONE_HIGH:    cfg_q.one_high_cycles    <= cfg_data[7:0];
				REG_ONE_LOW:     cfg_q.one_low_cycles     <= cfg_data[7:0];
				REG_ZERO_HIGH:   cfg_q.zero_high_cycles   <= cfg_data[7:0];
				REG_ZERO_LOW:    cfg_q.zero_low_cycles    <= cfg_data[7:0];
				REG_FRAME_RESET: cfg_q.frame_reset_cycles <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lowpe_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.colour_byte    (colour_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.head           (head),
		.head_pop       (head_pop)
	);

	lowpe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.head        (head),
		.head_pop    (head_pop),
		.empty       (empty),
		.pop         (pop),
		.line_level  (line_level),
		.hold_cycles (hold_cycles),
		.run_end     (run_end)
	);

endmodule
